// ----- rtl/skti_pkg.sv -----
// skti_pkg: shared types, op and status codes for the sorted key table
// used by skti_cell and sorted_key_table_insert; no dependencies
package skti_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_CLEARED  = 3'd3;
  localparam logic [2:0] ST_READ_OK  = 3'd4;
  localparam logic [2:0] ST_BAD_IDX  = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  read_index;
    logic [63:0] host_key;
    logic [31:0] window_start;
    logic [63:0] window_key;
    logic        window_kind;
    logic [63:0] cur_window_key;
    logic        cur_status;
    logic        cur_kind;
    logic [31:0] cur_start;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  position;
    logic [6:0]  fill;
    logic [63:0] out_host_key;
    logic [31:0] out_window_start;
    logic [63:0] out_window_key;
    logic        out_window_kind;
    logic [63:0] out_cur_window_key;
    logic        out_cur_status;
    logic        out_cur_kind;
    logic [31:0] out_cur_start;
  } result_t;

  // one stored table entry
  typedef struct packed {
    logic [63:0] host_key;
    logic [31:0] window_start;
    logic [63:0] window_key;
    logic        window_kind;
    logic [63:0] cur_window_key;
    logic        cur_status;
    logic        cur_kind;
    logic [31:0] cur_start;
  } entry_t;

  typedef struct packed {
    logic capture;  // latch compare flags for a new transaction
    logic shift;    // insert: move entries up and write the new one
  } cell_ctl_t;

  typedef struct packed {
    logic below;    // stored key is below the searched key
    logic sel;      // this cell is the lower-bound position
    logic eq;       // stored key equals the searched key
    logic rd;       // this cell is addressed by read_index
  } cell_flag_t;

  function automatic entry_t cmd_entry(input cmd_t c);
    entry_t e;
    e.host_key       = c.host_key;
    e.window_start   = c.window_start;
    e.window_key     = c.window_key;
    e.window_kind    = c.window_kind;
    e.cur_window_key = c.cur_window_key;
    e.cur_status     = c.cur_status;
    e.cur_kind       = c.cur_kind;
    e.cur_start      = c.cur_start;
    return e;
  endfunction

endpackage

// ----- rtl/skti_cell.sv -----
// skti_cell: one table slot, holds an entry, compares it with the searched key
// and takes its left neighbor's entry on insert; depends on skti_pkg
module skti_cell #(
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  skti_pkg::cmd_t         cmd,
  input  skti_pkg::entry_t       ins,
  input  skti_pkg::entry_t       left,
  input  logic                   left_below,
  input  logic                   valid,
  input  skti_pkg::cell_ctl_t    ctl,
  output skti_pkg::entry_t       entry,
  output skti_pkg::cell_flag_t   flag
);
  import skti_pkg::*;

  localparam logic [31:0] IDX_W = 32'(IDX);

  logic below;
  logic eq;
  logic rd;
  logic key_lt;
  logic key_eq;
  logic sel;

  assign key_lt = {entry.host_key, entry.window_start, entry.window_key}
                < {cmd.host_key, cmd.window_start, cmd.window_key};
  assign key_eq = {entry.host_key, entry.window_start, entry.window_key}
               == {cmd.host_key, cmd.window_start, cmd.window_key};

  // lower bound sits where the below run ends
  assign sel = left_below & ~below;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      below <= valid & key_lt;
      eq    <= valid & key_eq;
      rd    <= valid & ({26'd0, cmd.read_index} == IDX_W);
    end
    if (ctl.shift) begin
      if (sel) begin
        entry <= ins;
      end else if (!below) begin
        entry <= left;
      end
    end
  end

  assign flag.below = below;
  assign flag.sel   = sel;
  assign flag.eq    = eq;
  assign flag.rd    = rd;

endmodule

// ----- rtl/sorted_key_table_insert.sv -----
// sorted_key_table_insert: sorted key table with lookup-or-insert over a cell chain
// depends on skti_pkg and skti_cell
// result strobe (done) is registered from the update state entered on accept, for clear, lookup and read
// a new transaction is not taken while busy; busy is high for the cycle after accept,
//   when the cells shift on the flags they captured at accept and the result is registered
// reset: synchronous rst empties the table (fill 0); stored entries are not cleared
// op 3 is taken and produces no result; the receiver cannot stall done
module sorted_key_table_insert #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  skti_pkg::cmd_t     cmd,
  output logic               done,
  output skti_pkg::result_t  result
);
  import skti_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic               state;
  logic               state_next;
  logic [CNT_W-1:0]   count;
  cmd_t               cur;
  logic               accept;

  entry_t             cell_entry [TABLE_DEPTH];
  cell_flag_t         cell_flag  [TABLE_DEPTH];
  cell_ctl_t          ctl;
  entry_t             ins;

  logic               any_found;
  logic               any_rd;
  logic               full;
  logic [5:0]         look_pos;
  logic [5:0]         found_pos;
  entry_t             found_entry;
  entry_t             rd_entry;

  assign busy   = (state == ST_UPD);
  assign accept = start & ~busy;
  assign ins    = cmd_entry(cur);
  assign full   = (count >= CNT_W'(TABLE_DEPTH));

  assign ctl.capture = accept;
  assign ctl.shift   = (state == ST_UPD) & (cur.op == OP_LOOKUP) & ~any_found & ~full;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    skti_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .ins        (ins),
      .left       ((i == 0) ? entry_t'('0) : cell_entry[(i == 0) ? 0 : i - 1]),
      .left_below ((i == 0) ? 1'b1 : cell_flag[(i == 0) ? 0 : i - 1].below),
      .valid      (count > CNT_W'(i)),
      .ctl        (ctl),
      .entry      (cell_entry[i]),
      .flag       (cell_flag[i])
    );
  end

  // or-reduce the one-hot selections into position and entry data
  always_comb begin
    any_found   = 1'b0;
    any_rd      = 1'b0;
    look_pos    = '0;
    found_pos   = '0;
    found_entry = '0;
    rd_entry    = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cell_flag[i].sel) begin
        look_pos = look_pos | 6'(i);
      end
      if (cell_flag[i].sel & cell_flag[i].eq) begin
        any_found   = 1'b1;
        found_pos   = found_pos | 6'(i);
        found_entry = found_entry | cell_entry[i];
      end
      if (cell_flag[i].rd) begin
        any_rd   = 1'b1;
        rd_entry = rd_entry | cell_entry[i];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  function automatic result_t make_result(input logic [2:0] st, input logic [5:0] pos,
                                          input logic [6:0] fl, input entry_t e);
    result_t r;
    r.status             = st;
    r.position           = pos;
    r.fill               = fl;
    r.out_host_key       = e.host_key;
    r.out_window_start   = e.window_start;
    r.out_window_key     = e.window_key;
    r.out_window_kind    = e.window_kind;
    r.out_cur_window_key = e.cur_window_key;
    r.out_cur_status     = e.cur_status;
    r.out_cur_kind       = e.cur_kind;
    r.out_cur_start      = e.cur_start;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_UPD) begin
        unique case (cur.op)
          OP_CLEAR: begin
            count  <= '0;
            done   <= 1'b1;
            result <= make_result(ST_CLEARED, 6'd0, 7'd0, '0);
          end
          OP_READ: begin
            done <= 1'b1;
            if (any_rd) begin
              result <= make_result(ST_READ_OK, cur.read_index, 7'(count), rd_entry);
            end else begin
              result <= make_result(ST_BAD_IDX, 6'd0, 7'(count), '0);
            end
          end
          OP_LOOKUP: begin
            done <= 1'b1;
            if (any_found) begin
              result <= make_result(ST_FOUND, found_pos, 7'(count), found_entry);
            end else if (full) begin
              result <= make_result(ST_FULL, 6'd0, 7'(count), '0);
            end else begin
              count  <= count + CNT_W'(1);
              result <= make_result(ST_INSERTED, look_pos, 7'(count + CNT_W'(1)), ins);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= cmd;
    end
  end

endmodule

// ----- sim/skti_table_checker.sv -----
`timescale 1ns / 1ps
// skti_table_checker: watches the command and result channels of the sorted key table,
// predicts each result from a shadow table and compares it field by field
// depends on skti_pkg
module skti_table_checker #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  skti_pkg::cmd_t    cmd,
  input  logic              done,
  input  skti_pkg::result_t result,
  output int                err_count,
  output int                pending,
  output int                checked,
  output int                full_hits
);
  import skti_pkg::*;

  entry_t  shadow_tab [DEPTH];
  int      shadow_fill = 0;
  result_t expected_results [$];
  result_t want;
  result_t predicted;
  int      n_err = 0;
  int      n_pending = 0;
  int      n_checked = 0;
  int      n_full = 0;

  assign err_count = n_err;
  assign pending   = n_pending;
  assign checked   = n_checked;
  assign full_hits = n_full;

  // host id most significant, then window start, then window id
  function automatic logic [159:0] sort_key(input entry_t e);
    return {e.host_key, e.window_start, e.window_key};
  endfunction

  // applies one transaction to the shadow table, returns the result it must produce
  function automatic result_t apply_table_op(input cmd_t c);
    result_t r;
    entry_t  e;
    int      pos;
    int      i;
    logic    with_entry;
    r = '0;
    e = '0;
    pos = 0;
    with_entry = 1'b0;
    case (c.op)
      OP_CLEAR: begin
        shadow_fill = 0;
        r.status = ST_CLEARED;
      end
      OP_READ: begin
        if (int'(c.read_index) < shadow_fill) begin
          pos = int'(c.read_index);
          e = shadow_tab[pos];
          with_entry = 1'b1;
          r.status = ST_READ_OK;
        end else begin
          r.status = ST_BAD_IDX;
        end
      end
      default: begin
        e.host_key       = c.host_key;
        e.window_start   = c.window_start;
        e.window_key     = c.window_key;
        e.window_kind    = c.window_kind;
        e.cur_window_key = c.cur_window_key;
        e.cur_status     = c.cur_status;
        e.cur_kind       = c.cur_kind;
        e.cur_start      = c.cur_start;
        // lower bound: first stored key not below the searched one
        while (pos < shadow_fill && sort_key(shadow_tab[pos]) < sort_key(e)) pos++;
        if (pos < shadow_fill && sort_key(shadow_tab[pos]) == sort_key(e)) begin
          e = shadow_tab[pos];
          with_entry = 1'b1;
          r.status = ST_FOUND;
        end else if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_fill; i > pos; i--) shadow_tab[i] = shadow_tab[i - 1];
          shadow_tab[pos] = e;
          shadow_fill++;
          with_entry = 1'b1;
          r.status = ST_INSERTED;
        end
      end
    endcase
    r.fill = shadow_fill[6:0];
    if (with_entry) begin
      r.position           = pos[5:0];
      r.out_host_key       = e.host_key;
      r.out_window_start   = e.window_start;
      r.out_window_key     = e.window_key;
      r.out_window_kind    = e.window_kind;
      r.out_cur_window_key = e.cur_window_key;
      r.out_cur_status     = e.cur_status;
      r.out_cur_kind       = e.cur_kind;
      r.out_cur_start      = e.cur_start;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_fill = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          n_err++;
          $display("%0t: result with no transaction outstanding, status %0d, position %0d",
                   $time, result.status, result.position);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(result.status));
          check_field("position", 64'(want.position), 64'(result.position));
          check_field("fill", 64'(want.fill), 64'(result.fill));
          check_field("out_host_key", want.out_host_key, result.out_host_key);
          check_field("out_window_start", 64'(want.out_window_start),
                      64'(result.out_window_start));
          check_field("out_window_key", want.out_window_key, result.out_window_key);
          check_field("out_window_kind", 64'(want.out_window_kind),
                      64'(result.out_window_kind));
          check_field("out_cur_window_key", want.out_cur_window_key,
                      result.out_cur_window_key);
          check_field("out_cur_status", 64'(want.out_cur_status),
                      64'(result.out_cur_status));
          check_field("out_cur_kind", 64'(want.out_cur_kind), 64'(result.out_cur_kind));
          check_field("out_cur_start", 64'(want.out_cur_start), 64'(result.out_cur_start));
          n_checked++;
        end
      end
      // the undefined op is taken but answers nothing
      if (start && !busy &&
          (cmd.op == OP_CLEAR || cmd.op == OP_LOOKUP || cmd.op == OP_READ)) begin
        predicted = apply_table_op(cmd);
        if (predicted.status == ST_FULL) n_full++;
        expected_results.push_back(predicted);
      end
    end
    n_pending = expected_results.size();
  end

endmodule

// ----- sim/tb_sorted_key_table_insert.sv -----
`timescale 1ns / 1ps
// tb_sorted_key_table_insert: drives clear, lookup-or-insert and read transactions into
// the sorted key table; depends on skti_pkg, sorted_key_table_insert and skti_table_checker
module tb_sorted_key_table_insert;
  import skti_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;  // undefined op, taken without a result
  localparam int DEPTH = 64;
  localparam int TOTAL_ITEMS = 1375;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;
  int      err_count, pending, checked, full_hits;

  int idle_pct = 0;
  int sent = 0;
  int n_lookup = 0, n_read = 0, n_clear = 0, n_none = 0;
  int since_clear = 0;  // lookups since the last clear, bounds read indices

  logic [63:0] host_pool [8];
  logic [31:0] start_pool [8];
  logic [63:0] win_pool [8];
  int n_host, n_start, n_win;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_key_table_insert #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk, .rst, .start, .busy, .cmd, .done, .result
  );

  skti_table_checker #(.DEPTH(DEPTH)) u_check (
    .clk, .rst, .start, .busy, .cmd, .done, .result,
    .err_count, .pending, .checked, .full_hits
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pool64();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(15));
      default: return rand64();
    endcase
  endfunction

  function automatic logic [31:0] pool32();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t rand_cmd(input logic [1:0] op);
    cmd_t c;
    c.op             = op;
    c.read_index     = 6'($urandom_range(63));
    c.host_key       = rand64();
    c.window_start   = $urandom;
    c.window_key     = rand64();
    c.window_kind    = 1'($urandom_range(1));
    c.cur_window_key = rand64();
    c.cur_status     = 1'($urandom_range(1));
    c.cur_kind       = 1'($urandom_range(1));
    c.cur_start      = $urandom;
    return c;
  endfunction

  // holds start until the transaction is taken; start stays high into the next one
  task automatic send(input cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    case (c.op)
      OP_CLEAR:  n_clear++;
      OP_LOOKUP: n_lookup++;
      OP_READ:   n_read++;
      default:   n_none++;
    endcase
  endtask

  initial begin
    cmd_t c;
    int   i;
    int   pick;
    int   budget;
    int   idx_hi;
    logic fill_run;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part
    c = rand_cmd(OP_CLEAR);
    send(c);
    c = rand_cmd(OP_READ);
    c.read_index = '0;
    send(c);                                   // read of an empty table
    c = '0;
    c.op = OP_LOOKUP;
    send(c);                                   // smallest key, zero payload
    c = '1;
    c.op = OP_LOOKUP;
    send(c);                                   // largest key, all-ones payload
    c = rand_cmd(OP_LOOKUP);
    c.host_key = '1; c.window_start = '0; c.window_key = '0;
    send(c);                                   // same host as the largest, sorts below it
    c = rand_cmd(OP_LOOKUP);
    c.host_key = '0; c.window_start = '1; c.window_key = '0;
    send(c);
    c = rand_cmd(OP_LOOKUP);
    c.host_key = '0; c.window_start = '0; c.window_key = '1;
    send(c);
    c = rand_cmd(OP_LOOKUP);
    c.host_key = '0; c.window_start = '0; c.window_key = '0;
    send(c);                                   // key present, stored payload kept
    c = rand_cmd(OP_LOOKUP);
    c.host_key = '0; c.window_start = '0; c.window_key = 64'd1;
    send(c);                                   // lands between neighbors
    for (i = 0; i < 8; i++) begin
      c = rand_cmd(OP_READ);
      c.read_index = 6'(i);
      send(c);
    end
    c = rand_cmd(OP_READ);
    c.read_index = '1;
    send(c);
    c = rand_cmd(OP_NONE);
    send(c);
    c = '1;
    c.op = OP_LOOKUP;
    send(c);                                   // found after the undefined op
    c = rand_cmd(OP_CLEAR);
    send(c);
    c = rand_cmd(OP_READ);
    c.read_index = '0;
    send(c);
    c = rand_cmd(OP_LOOKUP);
    send(c);

    // random part: runs of lookups over a small key pool, some long enough to fill the table
    while (sent < TOTAL_ITEMS) begin
      fill_run = ($urandom_range(3) == 0);
      n_host  = fill_run ? 4 : $urandom_range(1, 4);
      n_start = fill_run ? 4 : $urandom_range(1, 4);
      n_win   = fill_run ? 8 : $urandom_range(2, 8);
      for (i = 0; i < 8; i++) begin
        host_pool[i]  = pool64();
        start_pool[i] = pool32();
        win_pool[i]   = pool64();
      end
      budget = fill_run ? $urandom_range(100, 140) : $urandom_range(8, 40);
      c = rand_cmd(OP_CLEAR);
      send(c);
      since_clear = 0;
      while (since_clear < budget && sent < TOTAL_ITEMS) begin
        case ((sent / 150) % 3)
          0: idle_pct = 0;
          1: idle_pct = 86;
          default: idle_pct = 15;
        endcase
        pick = $urandom_range(99);
        if (pick < 60) begin
          c = rand_cmd(OP_LOOKUP);
          c.host_key     = host_pool[$urandom_range(n_host - 1)];
          c.window_start = start_pool[$urandom_range(n_start - 1)];
          c.window_key   = win_pool[$urandom_range(n_win - 1)];
          since_clear++;
        end else if (pick < 68) begin
          c = rand_cmd(OP_LOOKUP);
          since_clear++;
        end else if (pick < 92) begin
          c = rand_cmd(OP_READ);
          idx_hi = (since_clear > 63) ? 63 : since_clear;
          if ($urandom_range(4) != 0) c.read_index = 6'($urandom_range(idx_hi));
        end else if (pick < 97 || fill_run) begin
          c = rand_cmd(OP_NONE);
        end else begin
          c = rand_cmd(OP_CLEAR);
          since_clear = 0;
        end
        send(c);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d transactions: %0d lookups, %0d reads, %0d clears, %0d undefined ops",
             sent, n_lookup, n_read, n_clear, n_none);
    $display("%0d results compared, %0d lookups refused by a full table", checked, full_hits);
    if (err_count == 0) begin
      $display("tb_sorted_key_table_insert: clean");
    end else begin
      $display("tb_sorted_key_table_insert: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_sorted_key_table_insert: errors");
    $finish;
  end

endmodule
